FILE: hdl/pebd_pkg.sv
// Shared constants, register indexes and unit request types for the profile edge break detector.
`timescale 1ns / 1ps
package pebd_pkg;

  localparam int MAX_HALF_LENGTH = 4096;

  localparam int HL_W   = 13;
  localparam int SAMP_W = 16;
  localparam int POS_W  = 14;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 3;

  localparam int MUL_A_W = 64;
  localparam int MUL_B_W = 32;
  localparam int DIV_W   = 64;
  localparam int DVS_W   = 49;
  localparam int STEP_W  = 7;

  localparam logic [IDX_W-1:0] CFG_HALF_LENGTH   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_SCAN_BACKWARD = 3'd1;
  localparam logic [IDX_W-1:0] CFG_STRONG_THRESH = 3'd2;
  localparam logic [IDX_W-1:0] CFG_WEAK_THRESH   = 3'd3;
  localparam logic [IDX_W-1:0] CFG_LOW_RATIO     = 3'd4;
  localparam logic [IDX_W-1:0] CFG_DIST_RATIO    = 3'd5;
  localparam logic [IDX_W-1:0] CFG_SEARCH_RATIO  = 3'd6;

  localparam logic [12:0] RST_HALF_LENGTH   = 13'd512;
  localparam logic [11:0] RST_STRONG_THRESH = 12'd896;
  localparam logic [11:0] RST_WEAK_THRESH   = 12'd768;
  localparam logic [7:0]  RST_LOW_RATIO     = 8'd219;
  localparam logic [7:0]  RST_DIST_RATIO    = 8'd205;
  localparam logic [7:0]  RST_SEARCH_RATIO  = 8'd169;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DVS_W-1:0]  rem_init;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

endpackage

FILE: hdl/pebd_mul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle, stops when no bits remain.
`timescale 1ns / 1ps
module pebd_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  pebd_pkg::mul_req_t           req,
  output logic                         done,
  output logic [pebd_pkg::MUL_A_W-1:0] product
);

  logic                         run;
  logic [pebd_pkg::MUL_A_W-1:0] areg;
  logic [pebd_pkg::MUL_B_W-1:0] breg;
  logic [pebd_pkg::MUL_A_W-1:0] acc;

  assign done    = run && (breg == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (req.start) begin
      run <= 1'b1;
    end else if (done) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      areg <= req.a;
      breg <= req.b;
      acc  <= '0;
    end else if (run && breg != '0) begin
      if (breg[0]) begin
        acc <= acc + areg;
      end
      areg <= {areg[pebd_pkg::MUL_A_W-2:0], 1'b0};
      breg <= {1'b0, breg[pebd_pkg::MUL_B_W-1:1]};
    end
  end

endmodule

FILE: hdl/pebd_div.sv
// Restoring divider: one quotient bit per cycle, with a preloadable partial remainder.
`timescale 1ns / 1ps
module pebd_div (
  input  logic                       clk,
  input  logic                       rst,
  input  pebd_pkg::div_req_t         req,
  output logic                       done,
  output logic [pebd_pkg::DIV_W-1:0] quotient
);

  logic                        run;
  logic [pebd_pkg::STEP_W-1:0] cnt;
  logic [pebd_pkg::DVS_W-1:0]  rem;
  logic [pebd_pkg::DVS_W-1:0]  dvs;
  logic [pebd_pkg::DIV_W-1:0]  quo;
  logic [pebd_pkg::DVS_W:0]    trial;
  logic [pebd_pkg::DVS_W:0]    diff;
  logic                        ge;

  assign done     = run && (cnt == '0);
  assign quotient = quo;

  always_comb begin
    trial = {rem, quo[pebd_pkg::DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (req.start) begin
      run <= 1'b1;
    end else if (done) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      quo <= req.dividend;
      dvs <= req.divisor;
      cnt <= req.steps;
    end else if (run && cnt != '0) begin
      rem <= ge ? diff[pebd_pkg::DVS_W-1:0] : trial[pebd_pkg::DVS_W-1:0];
      quo <= {quo[pebd_pkg::DIV_W-2:0], ge};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

FILE: hdl/profile_edge_break_detector_unit.sv
// Top level of the profile edge break detector: sequencer, scan state and handshakes.
`timescale 1ns / 1ps
// Units: every product goes through one bit-serial multiplier (one multiplier bit per
//   cycle) and every quotient through one restoring divider (one bit per cycle).
// Throughput: one sample at a time; the next is taken once the sequencer is back in idle,
//   while a finished result may still sit in the output register.
// Reset: configuration returns to its defaults, the scan goes idle, the output empties.
module profile_edge_break_detector_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pebd_pkg::SAMP_W-1:0]       sample,
  input  logic                              first,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic signed [pebd_pkg::POS_W-1:0] cut_pos,
  input  logic                              cfg_we,
  input  logic [pebd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pebd_pkg::CFG_W-1:0]        cfg_data
);

  // Sequencer steps
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SXX  = 5'd1;   // j*j into sum_xx
  localparam logic [4:0] ST_SXY  = 5'd2;   // j*y into sum_xy
  localparam logic [4:0] ST_SYY  = 5'd3;   // y*y into sum_yy
  localparam logic [4:0] ST_TLS  = 5'd4;   // strong * low ratio
  localparam logic [4:0] ST_TLW  = 5'd5;   // weak * low ratio
  localparam logic [4:0] ST_VLS  = 5'd6;   // onset bounds times variance
  localparam logic [4:0] ST_VLW  = 5'd7;
  localparam logic [4:0] ST_VS   = 5'd8;   // cut bounds times variance
  localparam logic [4:0] ST_VW   = 5'd9;
  localparam logic [4:0] ST_STOP = 5'd10;  // search limit
  localparam logic [4:0] ST_DJ   = 5'd11;  // dist ratio * j
  localparam logic [4:0] ST_DEC  = 5'd12;  // onset latch and cut decision
  localparam logic [4:0] ST_FA   = 5'd13;  // n*sum_xx
  localparam logic [4:0] ST_FC   = 5'd14;  // sum_x^2, form D
  localparam logic [4:0] ST_FPA  = 5'd15;  // n*sum_xy
  localparam logic [4:0] ST_FPC  = 5'd16;  // sum_x*sum_y, form P
  localparam logic [4:0] ST_FK   = 5'd17;  // slope division
  localparam logic [4:0] ST_FKS  = 5'd18;  // slope * sum_x, form intercept numerator
  localparam logic [4:0] ST_FB   = 5'd19;  // intercept division by n
  localparam logic [4:0] ST_FNK  = 5'd20;  // n * slope, prediction
  localparam logic [4:0] ST_FYA  = 5'd21;  // n*sum_yy
  localparam logic [4:0] ST_FYC  = 5'd22;  // sum_y^2
  localparam logic [4:0] ST_FT1  = 5'd23;  // explained energy, high part
  localparam logic [4:0] ST_FT2  = 5'd24;  // explained energy, low part
  localparam logic [4:0] ST_FNN  = 5'd25;  // n*n
  localparam logic [4:0] ST_FV   = 5'd26;  // residual variance division
  localparam logic [4:0] ST_TAIL = 5'd27;  // advance index, end of range check
  localparam logic [4:0] ST_EMIT = 5'd28;  // hand result to output register

  // Configuration
  logic [12:0] half_length;
  logic        scan_backward;
  logic [11:0] strong_thresh;
  logic [11:0] weak_thresh;
  logic [7:0]  low_ratio;
  logic [7:0]  dist_ratio;
  logic [7:0]  search_ratio;

  // Scan state
  logic [12:0]        index;
  logic [23:0]        sum_x;
  logic [35:0]        sum_xx;
  logic [28:0]        sum_y;
  logic [40:0]        sum_xy;
  logic [44:0]        sum_yy;
  logic signed [31:0] prediction;
  logic [31:0]        residual_var;
  logic               active;
  logic               pred_ok;
  logic               low_s;
  logic               low_w;
  logic               fb_set;
  logic [12:0]        onset_s;
  logic [12:0]        onset_w;
  logic [12:0]        fallback_pos;

  // Work registers
  logic [4:0]  step;
  logic        launched;
  logic [15:0] y;
  logic [19:0] tls;
  logic [19:0] tlw;
  logic        gt_low_s;
  logic        gt_low_w;
  logic        gt_s;
  logic        gt_w;
  logic [20:0] stop_lim;
  logic [20:0] dj;
  logic [63:0] tmp;
  logic [48:0] d_reg;
  logic [63:0] pmag;
  logic        kneg;
  logic [31:0] kmag;
  logic        bneg;
  logic [63:0] syy;
  logic        res_found;
  logic [13:0] res_pos;

  // Units
  pebd_pkg::mul_req_t mreq;
  pebd_pkg::div_req_t dreq;
  logic               mul_done;
  logic [63:0]        mul_p;
  logic               div_done;
  logic [63:0]        div_q;
  logic               mul_op;
  logic               div_op;

  pebd_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .done    (mul_done),
    .product (mul_p)
  );

  pebd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (dreq),
    .done     (div_done),
    .quotient (div_q)
  );

  // Derived values
  logic [12:0]        hl_eff;
  logic [12:0]        n13;
  logic [63:0]        n64;
  logic [31:0]        n32;
  logic [63:0]        j64;
  logic [31:0]        j32;
  logic [31:0]        varf;
  logic signed [33:0] dv;
  logic [32:0]        diff;
  logic [63:0]        d16;
  logic [63:0]        d8;
  logic               ls_new;
  logic               lw_new;
  logic [12:0]        os_new;
  logic [12:0]        ow_new;
  logic               stop_hit;
  logic               cut_hit;
  logic               fb_hit;
  logic [63:0]        bnum;
  logic [63:0]        kqn;
  logic [63:0]        pv;
  logic [63:0]        pm;
  logic [31:0]        pred_next;
  logic [63:0]        t_sum;
  logic               out_free;
  logic               accept;

  function automatic logic [13:0] pos_of(input logic [12:0] p, input logic back);
    logic [13:0] v;
    v = {1'b0, p};
    return back ? (14'd0 - v) : v;
  endfunction

  assign in_ready = (step == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    if (half_length == 13'd0) begin
      hl_eff = 13'd1;
    end else if (half_length > 13'(pebd_pkg::MAX_HALF_LENGTH)) begin
      hl_eff = 13'(pebd_pkg::MAX_HALF_LENGTH);
    end else begin
      hl_eff = half_length;
    end
    n13  = index + 13'd1;
    n64  = {51'd0, n13};
    n32  = {19'd0, n13};
    j64  = {51'd0, index};
    j32  = {19'd0, index};
    varf = (residual_var < 32'd65536) ? 32'd65536 : residual_var;

    // Residual against the held prediction
    dv   = $signed({10'd0, y, 8'd0}) - 34'(prediction);
    diff = dv[33] ? 33'(-dv) : dv[32:0];
    d16  = {15'd0, diff, 16'd0};
    d8   = {23'd0, diff, 8'd0};

    // Onset latch, then search stop, strong cut and fallback in that order
    ls_new   = low_s | gt_low_s;
    lw_new   = low_w | gt_low_w;
    os_new   = (!low_s && gt_low_s) ? index : onset_s;
    ow_new   = (!low_w && gt_low_w) ? index : onset_w;
    stop_hit = ({index, 8'd0} >= stop_lim);
    cut_hit  = gt_s && ls_new && ({os_new, 8'd0} >= dj);
    fb_hit   = !fb_set && gt_w && lw_new && ({ow_new, 8'd0} >= dj);

    // Intercept numerator: sum_y*2^16 - k*sum_x
    bnum = kneg ? ({19'd0, sum_y, 16'd0} + mul_p) : ({19'd0, sum_y, 16'd0} - mul_p);

    // Prediction at x = j+1, saturated to 32 bits
    kqn = kneg ? (64'd0 - mul_p) : mul_p;
    pv  = kqn + tmp;
    pm  = (pv[63] ? (64'd0 - pv) : pv) >> 8;
    if (pv[63]) begin
      pred_next = (pm > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - pm[31:0]);
    end else begin
      pred_next = (pm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : pm[31:0];
    end

    t_sum = tmp + (mul_p >> 16);
  end

  // Operand selection for the shared units
  always_comb begin
    mreq   = '0;
    dreq   = '0;
    mul_op = 1'b1;
    div_op = 1'b0;
    unique case (step)
      ST_SXX:  begin mreq.a = j64;                   mreq.b = j32;              end
      ST_SXY:  begin mreq.a = {48'd0, y};            mreq.b = j32;              end
      ST_SYY:  begin mreq.a = {48'd0, y};            mreq.b = {16'd0, y};       end
      ST_TLS:  begin mreq.a = {52'd0, strong_thresh}; mreq.b = {24'd0, low_ratio}; end
      ST_TLW:  begin mreq.a = {52'd0, weak_thresh};  mreq.b = {24'd0, low_ratio}; end
      ST_VLS:  begin mreq.a = {32'd0, varf};         mreq.b = {12'd0, tls};     end
      ST_VLW:  begin mreq.a = {32'd0, varf};         mreq.b = {12'd0, tlw};     end
      ST_VS:   begin mreq.a = {32'd0, varf};         mreq.b = {20'd0, strong_thresh}; end
      ST_VW:   begin mreq.a = {32'd0, varf};         mreq.b = {20'd0, weak_thresh}; end
      ST_STOP: begin mreq.a = {51'd0, hl_eff};       mreq.b = {24'd0, search_ratio}; end
      ST_DJ:   begin mreq.a = j64;                   mreq.b = {24'd0, dist_ratio}; end
      ST_FA:   begin mreq.a = {28'd0, sum_xx};       mreq.b = n32;              end
      ST_FC:   begin mreq.a = {40'd0, sum_x};        mreq.b = {8'd0, sum_x};    end
      ST_FPA:  begin mreq.a = {23'd0, sum_xy};       mreq.b = n32;              end
      ST_FPC:  begin mreq.a = {35'd0, sum_y};        mreq.b = {8'd0, sum_x};    end
      ST_FKS:  begin mreq.a = {40'd0, sum_x};        mreq.b = kmag;             end
      ST_FNK:  begin mreq.a = {32'd0, kmag};         mreq.b = n32;              end
      ST_FYA:  begin mreq.a = {19'd0, sum_yy};       mreq.b = n32;              end
      ST_FYC:  begin mreq.a = {35'd0, sum_y};        mreq.b = {3'd0, sum_y};    end
      ST_FT1:  begin mreq.a = pmag >> 16;            mreq.b = kmag;             end
      ST_FT2:  begin mreq.a = {48'd0, pmag[15:0]};   mreq.b = kmag;             end
      ST_FNN:  begin mreq.a = n64;                   mreq.b = n32;              end
      ST_FK: begin
        mul_op        = 1'b0;
        div_op        = 1'b1;
        dreq.rem_init = {1'b0, pmag[63:16]};
        dreq.dividend = {pmag[15:0], 48'd0};
        dreq.divisor  = d_reg;
        dreq.steps    = 7'd32;
      end
      ST_FB: begin
        mul_op        = 1'b0;
        div_op        = 1'b1;
        dreq.dividend = tmp;
        dreq.divisor  = {36'd0, n13};
        dreq.steps    = 7'd64;
      end
      ST_FV: begin
        mul_op        = 1'b0;
        div_op        = 1'b1;
        dreq.dividend = syy;
        dreq.divisor  = d_reg;
        dreq.steps    = 7'd64;
      end
      default: begin
        mul_op = 1'b0;
      end
    endcase
    mreq.start = mul_op && !launched;
    dreq.start = div_op && !launched;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half_length   <= pebd_pkg::RST_HALF_LENGTH;
      scan_backward <= 1'b0;
      strong_thresh <= pebd_pkg::RST_STRONG_THRESH;
      weak_thresh   <= pebd_pkg::RST_WEAK_THRESH;
      low_ratio     <= pebd_pkg::RST_LOW_RATIO;
      dist_ratio    <= pebd_pkg::RST_DIST_RATIO;
      search_ratio  <= pebd_pkg::RST_SEARCH_RATIO;
    end else if (cfg_we) begin
      case (cfg_index)
        pebd_pkg::CFG_HALF_LENGTH:   half_length   <= cfg_data;
        pebd_pkg::CFG_SCAN_BACKWARD: scan_backward <= cfg_data[0];
        pebd_pkg::CFG_STRONG_THRESH: strong_thresh <= cfg_data[11:0];
        pebd_pkg::CFG_WEAK_THRESH:   weak_thresh   <= cfg_data[11:0];
        pebd_pkg::CFG_LOW_RATIO:     low_ratio     <= cfg_data[7:0];
        pebd_pkg::CFG_DIST_RATIO:    dist_ratio    <= cfg_data[7:0];
        pebd_pkg::CFG_SEARCH_RATIO:  search_ratio  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= ST_IDLE;
      launched     <= 1'b0;
      active       <= 1'b0;
      pred_ok      <= 1'b0;
      low_s        <= 1'b0;
      low_w        <= 1'b0;
      fb_set       <= 1'b0;
      index        <= '0;
      sum_x        <= '0;
      sum_xx       <= '0;
      sum_y        <= '0;
      sum_xy       <= '0;
      sum_yy       <= '0;
      prediction   <= '0;
      residual_var <= '0;
      onset_s      <= '0;
      onset_w      <= '0;
      fallback_pos <= '0;
    end else begin
      if (mreq.start || dreq.start) begin
        launched <= 1'b1;
      end
      if ((mul_op && mul_done) || (div_op && div_done)) begin
        launched <= 1'b0;
      end
      unique case (step)
        ST_IDLE: begin
          if (accept) begin
            y <= sample;
            if (first) begin
              // New scan: clear sums and flags, take this sample as j = 0
              active       <= 1'b1;
              pred_ok      <= 1'b0;
              low_s        <= 1'b0;
              low_w        <= 1'b0;
              fb_set       <= 1'b0;
              index        <= '0;
              sum_x        <= '0;
              sum_xx       <= '0;
              sum_y        <= '0;
              sum_xy       <= '0;
              sum_yy       <= '0;
              prediction   <= '0;
              residual_var <= '0;
              onset_s      <= '0;
              onset_w      <= '0;
              fallback_pos <= '0;
              step         <= ST_SXX;
            end else if (active) begin
              step <= ST_SXX;
            end
          end
        end
        ST_SXX: if (mul_done) begin
          sum_xx <= sum_xx + mul_p[35:0];
          sum_x  <= sum_x + {11'd0, index};
          sum_y  <= sum_y + {13'd0, y};
          step   <= ST_SXY;
        end
        ST_SXY: if (mul_done) begin
          sum_xy <= sum_xy + mul_p[40:0];
          step   <= ST_SYY;
        end
        ST_SYY: if (mul_done) begin
          sum_yy <= sum_yy + mul_p[44:0];
          if (pred_ok) begin
            step <= ST_TLS;
          end else if (index != '0) begin
            step <= ST_FA;
          end else begin
            step <= ST_TAIL;
          end
        end
        ST_TLS: if (mul_done) begin
          tls  <= mul_p[19:0];
          step <= ST_TLW;
        end
        ST_TLW: if (mul_done) begin
          tlw  <= mul_p[19:0];
          step <= ST_VLS;
        end
        ST_VLS: if (mul_done) begin
          gt_low_s <= (d16 > mul_p);
          step     <= ST_VLW;
        end
        ST_VLW: if (mul_done) begin
          gt_low_w <= (d16 > mul_p);
          step     <= ST_VS;
        end
        ST_VS: if (mul_done) begin
          gt_s <= (d8 > mul_p);
          step <= ST_VW;
        end
        ST_VW: if (mul_done) begin
          gt_w <= (d8 > mul_p);
          step <= ST_STOP;
        end
        ST_STOP: if (mul_done) begin
          stop_lim <= mul_p[20:0];
          step     <= ST_DJ;
        end
        ST_DJ: if (mul_done) begin
          dj   <= mul_p[20:0];
          step <= ST_DEC;
        end
        ST_DEC: begin
          low_s   <= ls_new;
          low_w   <= lw_new;
          onset_s <= os_new;
          onset_w <= ow_new;
          if (stop_hit) begin
            active    <= 1'b0;
            res_found <= fb_set;
            res_pos   <= fb_set ? pos_of(fallback_pos, scan_backward) : 14'd0;
            step      <= ST_EMIT;
          end else if (cut_hit) begin
            active    <= 1'b0;
            res_found <= 1'b1;
            res_pos   <= pos_of(index, scan_backward);
            step      <= ST_EMIT;
          end else begin
            if (fb_hit) begin
              fb_set       <= 1'b1;
              fallback_pos <= index;
            end
            step <= (index != '0) ? ST_FA : ST_TAIL;
          end
        end
        ST_FA: if (mul_done) begin
          tmp  <= mul_p;
          step <= ST_FC;
        end
        ST_FC: if (mul_done) begin
          d_reg <= (tmp > mul_p) ? 49'(tmp - mul_p) : 49'd0;
          step  <= ST_FPA;
        end
        ST_FPA: if (mul_done) begin
          tmp  <= mul_p;
          step <= ST_FPC;
        end
        ST_FPC: if (mul_done) begin
          kneg <= (mul_p > tmp);
          pmag <= (mul_p > tmp) ? (mul_p - tmp) : (tmp - mul_p);
          if (d_reg == '0) begin
            // Degenerate fit: slope is zero
            kmag <= '0;
            step <= ST_FKS;
          end else begin
            step <= ST_FK;
          end
        end
        ST_FK: if (div_done) begin
          kmag <= div_q[31:0];
          step <= ST_FKS;
        end
        ST_FKS: if (mul_done) begin
          bneg <= bnum[63];
          tmp  <= bnum[63] ? (64'd0 - bnum) : bnum;
          step <= ST_FB;
        end
        ST_FB: if (div_done) begin
          tmp  <= bneg ? (64'd0 - div_q) : div_q;
          step <= ST_FNK;
        end
        ST_FNK: if (mul_done) begin
          prediction <= $signed(pred_next);
          step       <= ST_FYA;
        end
        ST_FYA: if (mul_done) begin
          tmp  <= mul_p;
          step <= ST_FYC;
        end
        ST_FYC: if (mul_done) begin
          syy  <= (tmp > mul_p) ? (tmp - mul_p) : 64'd0;
          step <= ST_FT1;
        end
        ST_FT1: if (mul_done) begin
          tmp  <= mul_p;
          step <= ST_FT2;
        end
        ST_FT2: if (mul_done) begin
          syy  <= (syy > t_sum) ? (syy - t_sum) : 64'd0;
          step <= ST_FNN;
        end
        ST_FNN: if (mul_done) begin
          d_reg <= mul_p[48:0];
          step  <= ST_FV;
        end
        ST_FV: if (div_done) begin
          residual_var <= (div_q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
          pred_ok      <= 1'b1;
          step         <= ST_TAIL;
        end
        ST_TAIL: begin
          index <= n13;
          if (n13 >= hl_eff) begin
            active    <= 1'b0;
            res_found <= fb_set;
            res_pos   <= fb_set ? pos_of(fallback_pos, scan_backward) : 14'd0;
            step      <= ST_EMIT;
          end else begin
            step <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          // Hold until the output register can take the beat
          if (out_free) begin
            step <= ST_IDLE;
          end
        end
        default: step <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step == ST_EMIT && out_free) begin
      found   <= res_found;
      cut_pos <= $signed(res_pos);
    end
  end

  // Checks
  a_idle_no_unit: assert property (@(posedge clk) disable iff (rst)
    accept |-> !launched) else $error("sample taken while a unit request is open");

  a_nf_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (cut_pos == '0)) else $error("not-found beat with nonzero offset");

  a_first_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && first) |=> (active && step == ST_SXX)) else $error("new scan did not start");

  a_emit_inactive: assert property (@(posedge clk) disable iff (rst)
    (step == ST_EMIT) |-> !active) else $error("result emitted with scan still active");

endmodule

FILE: test/profile_edge_break_detector_unit_tb.sv
// Self-checking testbench for the profile edge break detector: directed and random scans against a predictor.
`timescale 1ns / 1ps
module profile_edge_break_detector_unit_tb;

  localparam int SETTLE_CYCLES = 700;
  localparam int STALL_LIMIT   = 6000;  // cycles with no beat on any channel

  typedef struct packed {
    logic [pebd_pkg::SAMP_W-1:0] sample;
    logic                        first;
  } sample_beat_t;

  typedef struct packed {
    logic                       found;
    logic [pebd_pkg::POS_W-1:0] cut_pos;
  } cut_result_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [pebd_pkg::SAMP_W-1:0]       sample = '0;
  logic                              first = 1'b0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              found;
  logic signed [pebd_pkg::POS_W-1:0] cut_pos;
  logic                              cfg_we = 1'b0;
  logic [pebd_pkg::IDX_W-1:0]        cfg_index = '0;
  logic [pebd_pkg::CFG_W-1:0]        cfg_data = '0;

  profile_edge_break_detector_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample), .first(first),
    .out_valid(out_valid), .out_ready(out_ready), .found(found), .cut_pos(cut_pos),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sample_beat_t pending_beats[$];
  cut_result_t  pending_cuts[$];
  int unsigned  sent_cnt = 0;
  int unsigned  taken_cnt = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  stall_cnt = 0;
  int unsigned  in_gap = 0;
  int unsigned  out_gap = 0;
  bit           quiet = 1'b0;  // no idling in the closing stretch

  // Predictor copy of the configuration registers.
  logic [12:0] m_half_length;
  logic        m_backward;
  logic [11:0] m_strong, m_weak;
  logic [7:0]  m_low_ratio, m_dist_ratio, m_search_ratio;

  // Predictor copy of the scan state.
  int unsigned       m_index;
  longint unsigned   m_sx, m_sxx, m_sy, m_sxy, m_syy;
  longint            m_pred;
  longint unsigned   m_var;
  bit                m_active, m_pred_ok, m_onset_s, m_onset_w, m_fallback_set;
  int unsigned       m_onset_s_pos, m_onset_w_pos, m_fallback_pos;

  function automatic logic [pebd_pkg::POS_W-1:0] edge_offset(int unsigned j);
    longint unsigned v;
    v = m_backward ? (64'd0 - longint'(j)) : longint'(j);
    return v[pebd_pkg::POS_W-1:0];
  endfunction

  function automatic void clear_scan();
    m_index = 0;
    m_sx = 0; m_sxx = 0; m_sy = 0; m_sxy = 0; m_syy = 0;
    m_pred = 0; m_var = 0;
    m_active = 0; m_pred_ok = 0; m_onset_s = 0; m_onset_w = 0; m_fallback_set = 0;
    m_onset_s_pos = 0; m_onset_w_pos = 0; m_fallback_pos = 0;
  endfunction

  // Fit a least-squares line to samples 0..j and update prediction and residual variance.
  function automatic void fit_profile_line(int unsigned j);
    longint unsigned n, a, c, d, pa, pc, pmag, kmag, q, r, bmag, pm, ya, yc, syy, t, sse, v;
    longint kq, bnum, bq, pv;
    bit kneg;
    n = longint'(j) + 1;
    a = n * m_sxx; c = m_sx * m_sx;
    d = (a > c) ? a - c : 0;
    pa = n * m_sxy; pc = m_sx * m_sy;
    kneg = pc > pa;
    pmag = kneg ? pc - pa : pa - pc;
    kmag = 0;
    if (d != 0) begin
      q = pmag / d; r = pmag % d;
      kmag = (q << 16) + (r << 16) / d;
    end
    kq = kneg ? -longint'(kmag) : longint'(kmag);
    bnum = longint'(m_sy << 16) - kq * longint'(m_sx);
    bmag = (bnum < 0) ? (64'd0 - longint'(bnum)) : longint'(bnum);
    bmag = bmag / n;
    bq = (bnum < 0) ? -longint'(bmag) : longint'(bmag);
    pv = longint'(n) * kq + bq;
    pm = (pv < 0) ? (64'd0 - longint'(pv)) : longint'(pv);
    pm = pm >> 8;
    if (pv < 0) begin
      if (pm > 64'h8000_0000) pm = 64'h8000_0000;
      m_pred = -longint'(pm);
    end else begin
      if (pm > 64'h7FFF_FFFF) pm = 64'h7FFF_FFFF;
      m_pred = longint'(pm);
    end
    ya = n * m_syy; yc = m_sy * m_sy;
    syy = (ya > yc) ? ya - yc : 0;
    t = kmag * (pmag >> 16) + ((kmag * (pmag & 64'hFFFF)) >> 16);
    sse = (syy > t) ? syy - t : 0;
    v = sse / (n * n);
    m_var = (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  // Advance the scan by one sample; return 1 with the cut result when the beat yields one.
  function automatic bit predict_cut(sample_beat_t b, output cut_result_t res);
    longint unsigned y, hl, diff, varf, d16, d8;
    longint dv;
    int unsigned j;
    res = '0;
    y = b.sample;
    if (b.first) begin
      clear_scan();
      m_active = 1;
    end
    if (!m_active) return 0;
    hl = m_half_length;
    if (hl < 1) hl = 1;
    if (hl > pebd_pkg::MAX_HALF_LENGTH) hl = pebd_pkg::MAX_HALF_LENGTH;
    j = m_index;
    m_sx += j;
    m_sxx += longint'(j) * j;
    m_sy += y;
    m_sxy += longint'(j) * y;
    m_syy += y * y;
    if (m_pred_ok) begin
      dv = longint'(y << 8) - m_pred;
      diff = (dv < 0) ? (64'd0 - longint'(dv)) : longint'(dv);
      varf = (m_var < 65536) ? 65536 : m_var;
      d16 = diff << 16;
      d8 = diff << 8;
      if (!m_onset_s && d16 > longint'(m_strong) * m_low_ratio * varf) begin
        m_onset_s = 1; m_onset_s_pos = j;
      end
      if (!m_onset_w && d16 > longint'(m_weak) * m_low_ratio * varf) begin
        m_onset_w = 1; m_onset_w_pos = j;
      end
      // Search range reached: close the scan before any cut test.
      if (longint'(j) * 256 >= hl * m_search_ratio) begin
        m_active = 0;
        if (m_fallback_set) res = '{1'b1, edge_offset(m_fallback_pos)};
        return 1;
      end
      if (d8 > longint'(m_strong) * varf && m_onset_s &&
          longint'(m_onset_s_pos) * 256 >= longint'(m_dist_ratio) * j) begin
        m_active = 0;
        res = '{1'b1, edge_offset(j)};
        return 1;
      end
      if (!m_fallback_set && d8 > longint'(m_weak) * varf && m_onset_w &&
          longint'(m_onset_w_pos) * 256 >= longint'(m_dist_ratio) * j) begin
        m_fallback_set = 1; m_fallback_pos = j;
      end
    end
    if (j >= 1) begin
      fit_profile_line(j);
      m_pred_ok = 1;
    end
    m_index = j + 1;
    if (longint'(m_index) >= hl) begin
      m_active = 0;
      if (m_fallback_set) res = '{1'b1, edge_offset(m_fallback_pos)};
      return 1;
    end
    return 0;
  endfunction

  // Track config writes and accepted samples at the rising edge.
  always @(posedge clk) begin
    cut_result_t res;
    if (rst) begin
      m_half_length <= pebd_pkg::RST_HALF_LENGTH;
      m_backward <= 1'b0;
      m_strong <= pebd_pkg::RST_STRONG_THRESH;
      m_weak <= pebd_pkg::RST_WEAK_THRESH;
      m_low_ratio <= pebd_pkg::RST_LOW_RATIO;
      m_dist_ratio <= pebd_pkg::RST_DIST_RATIO;
      m_search_ratio <= pebd_pkg::RST_SEARCH_RATIO;
      clear_scan();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pebd_pkg::CFG_HALF_LENGTH:   m_half_length <= cfg_data[12:0];
          pebd_pkg::CFG_SCAN_BACKWARD: m_backward <= cfg_data[0];
          pebd_pkg::CFG_STRONG_THRESH: m_strong <= cfg_data[11:0];
          pebd_pkg::CFG_WEAK_THRESH:   m_weak <= cfg_data[11:0];
          pebd_pkg::CFG_LOW_RATIO:     m_low_ratio <= cfg_data[7:0];
          pebd_pkg::CFG_DIST_RATIO:    m_dist_ratio <= cfg_data[7:0];
          pebd_pkg::CFG_SEARCH_RATIO:  m_search_ratio <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        taken_cnt++;
        if (predict_cut('{sample, first}, res)) pending_cuts.push_back(res);
      end
    end
  end

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Monitor: compare every result beat with the oldest pending cut.
  always @(posedge clk) begin
    cut_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_cuts.size() == 0) begin
        report_mismatch("unexpected result, cut_pos", cut_pos, 0);
      end else begin
        want = pending_cuts.pop_front();
        if (found !== want.found) report_mismatch("found", found, want.found);
        if (cut_pos !== want.cut_pos) report_mismatch("cut_pos", cut_pos, want.cut_pos);
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Driver: hold a beat until taken, then insert random gaps between beats.
  always @(negedge clk) begin
    sample_beat_t b;
    if (!rst) begin
      if (in_valid && taken_cnt < sent_cnt) begin
        // hold the current beat
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (pending_beats.size() != 0) begin
        b = pending_beats.pop_front();
        sample <= b.sample;
        first <= b.first;
        in_valid <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side backpressure in bursts.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [pebd_pkg::IDX_W-1:0] idx, int unsigned value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[pebd_pkg::CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until all beats are taken and all cuts checked, then let the block settle.
  task automatic drain();
    while (pending_beats.size() != 0 || taken_cnt != sent_cnt || in_valid ||
           pending_cuts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_beat(int unsigned s, bit f);
    pending_beats.push_back('{s[pebd_pkg::SAMP_W-1:0], f});
  endtask

  // Queue a profile: a ramp with optional noise and a step that may lie beyond its end.
  task automatic queue_profile(int unsigned len);
    int base, slope, noise, jump_at, jump, v;
    base = $urandom_range(0, 65535);
    slope = int'($urandom_range(0, 1024)) - 512;
    noise = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 2048);
    jump_at = $urandom_range(2, len + 2);
    jump = int'($urandom_range(0, 65535)) - 32768;
    for (int i = 0; i < len; i++) begin
      v = base + slope * i + (noise ? int'($urandom_range(0, noise)) - noise / 2 : 0);
      if (i >= jump_at) v += jump;
      if ($urandom_range(0, 40) == 0) v = $urandom_range(0, 1) ? 65535 : 0;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      push_beat(v, i == 0);
    end
  endtask

  task automatic random_config(output int unsigned hl_eff);
    int unsigned hl, sr;
    case ($urandom_range(0, 9))
      0: hl = $urandom_range(0, 3);
      1: hl = $urandom_range(0, 1) ? 4096 : 8191;
      default: hl = $urandom_range(4, 40);
    endcase
    sr = hl >= 256 ? $urandom_range(0, 8)
                   : ($urandom_range(0, 3) == 0 ? 255 : $urandom_range(0, 255));
    write_reg(pebd_pkg::CFG_HALF_LENGTH, hl);
    write_reg(pebd_pkg::CFG_SCAN_BACKWARD, $urandom_range(0, 1));
    write_reg(pebd_pkg::CFG_STRONG_THRESH,
              $urandom_range(0, 4) == 0 ? 4095 * $urandom_range(0, 1) : $urandom_range(0, 2000));
    write_reg(pebd_pkg::CFG_WEAK_THRESH,
              $urandom_range(0, 4) == 0 ? 4095 * $urandom_range(0, 1) : $urandom_range(0, 1800));
    write_reg(pebd_pkg::CFG_LOW_RATIO,
              $urandom_range(0, 4) == 0 ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255));
    write_reg(pebd_pkg::CFG_DIST_RATIO,
              $urandom_range(0, 4) == 0 ? 255 * $urandom_range(0, 1) : $urandom_range(0, 255));
    write_reg(pebd_pkg::CFG_SEARCH_RATIO, sr);
    hl_eff = hl == 0 ? 1 : (hl > 256 ? 60 : hl);
  endtask

  initial begin
    int unsigned queued, hl_eff, len;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: idle samples are dropped, then extreme samples under the defaults.
    push_beat(16'h1234, 1'b0);
    push_beat(0, 1'b1);
    push_beat(65535, 1'b0);
    push_beat(0, 1'b0);
    push_beat(0, 1'b0);
    push_beat(0, 1'b0);
    push_beat(65535, 1'b0);
    drain();
    // Short forward scan: flat line then a strong step, cut right away.
    write_reg(pebd_pkg::CFG_HALF_LENGTH, 12);
    write_reg(pebd_pkg::CFG_SEARCH_RATIO, 255);
    for (int i = 0; i < 8; i++) push_beat(16'h1000 + i, i == 0);
    push_beat(16'hF000, 1'b0);
    drain();
    // Backward scan with zero thresholds, restart in mid-scan, half length zero.
    write_reg(pebd_pkg::CFG_SCAN_BACKWARD, 1);
    write_reg(pebd_pkg::CFG_STRONG_THRESH, 0);
    write_reg(pebd_pkg::CFG_WEAK_THRESH, 0);
    for (int i = 0; i < 4; i++) push_beat(i * 300, i == 0);
    push_beat(500, 1'b1);
    drain();
    write_reg(pebd_pkg::CFG_HALF_LENGTH, 0);
    push_beat(777, 1'b1);
    push_beat(778, 1'b1);
    drain();

    // Random phases: new settings, then a few scans with some stray beats.
    queued = 0;
    while (queued < 500) begin
      if (queued > 420) quiet = 1'b1;
      random_config(hl_eff);
      repeat ($urandom_range(2, 4)) begin
        len = $urandom_range(1, hl_eff + 3);
        queue_profile(len);
        queued += len;
        if ($urandom_range(0, 4) == 0) begin
          push_beat($urandom_range(0, 65535), 1'b0);
          queued++;
        end
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/pebd_pkg.sv
hdl/pebd_mul.sv
hdl/pebd_div.sv
hdl/profile_edge_break_detector_unit.sv
test/profile_edge_break_detector_unit_tb.sv
